// ----- hdl/slinv_pkg.sv -----
// ----------------------------------------------------------------------------
// slinv_pkg - shared types and constants of the slope limiter inverse
// Constants, the queue entry, arithmetic unit request/response and the
// state type of the back end sequencer.
// ----------------------------------------------------------------------------
package slinv_pkg;

    // default configuration
    localparam int DATA_WIDTH_DEF        = 32;
    localparam int RATIO_FRAC_BITS_DEF   = 28;
    localparam int BISECT_STEPS_DEF      = 32;
    localparam int MAX_ORDER_DEF         = 9;
    localparam int SEARCH_LIMIT_LOG2_DEF = 6;

    // internal fixed point words are 64 bits wide
    localparam logic [63:0] CAP63     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RATIO_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SIGN  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_ONE   = 3'd3;
    localparam logic [2:0] ST_TWO   = 3'd4;
    localparam logic [2:0] ST_BELOW = 3'd5;

    // classified item between front and back end
    typedef struct packed {
        logic [63:0] dm;       // magnitude of difference
        logic [63:0] sm;       // magnitude of target slope
        logic [63:0] diff;     // raw difference bits, zero extended
        logic        dneg;
        logic        trivial;  // signs differ or an input is zero
        logic [3:0]  order;    // clamped limiter order
    } q_entry_t;

    // request to a multi-cycle arithmetic unit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } arith_req_t;

    // response from a multi-cycle arithmetic unit
    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } arith_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RATIO,
        S_ORD1,
        S_EXP,
        S_EXP_CHK,
        S_CROSS,
        S_CROSS_CHK,
        S_CROSS_END,
        S_BIS,
        S_BIS_CHK,
        S_FIN,
        S_FIN_W,
        S_EMIT,
        S_EV_START,
        S_EV_INV,
        S_EV_POW,
        S_EV_POW_W,
        S_EV_P,
        S_EV_T,
        S_EV_DEN,
        S_EV_DIV
    } back_state_t;

endpackage

// ----- hdl/slinv_fifo.sv -----
// ----------------------------------------------------------------------------
// slinv_fifo - two entry queue between front and back end
// Register based queue of classified items, push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module slinv_fifo
    import slinv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t pop_data
);

    q_entry_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/slinv_front.sv -----
// ----------------------------------------------------------------------------
// slinv_front - input side of the slope limiter inverse
// Holds the order register, takes input transfers, splits sign and
// magnitude and flags items that need no search.
// ----------------------------------------------------------------------------
module slinv_front
    import slinv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_ORDER  = MAX_ORDER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_diff,
    input  logic [DATA_WIDTH-1:0] in_slope,
    input  logic                  q_full,
    output logic                  q_push,
    output q_entry_t              q_data
);

    logic [3:0]            order_reg;
    logic [3:0]            order_clamped;
    logic                  dneg, sneg;
    logic [DATA_WIDTH-1:0] dabs, sabs;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            order_reg <= cfg_data;
        end
    end

    // order zero acts as one, large orders as the top order
    always_comb
    begin
        if (order_reg == 4'd0)
            order_clamped = 4'd1;
        else if (order_reg > 4'(MAX_ORDER))
            order_clamped = 4'(MAX_ORDER);
        else
            order_clamped = order_reg;
    end

    // sign and magnitude split
    assign dneg = in_diff[DATA_WIDTH-1];
    assign sneg = in_slope[DATA_WIDTH-1];
    assign dabs = dneg ? (~in_diff + 1'b1) : in_diff;
    assign sabs = sneg ? (~in_slope + 1'b1) : in_slope;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data.dm      = 64'(dabs);
        q_data.sm      = 64'(sabs);
        q_data.diff    = 64'(in_diff);
        q_data.dneg    = dneg;
        q_data.trivial = (in_diff == '0) || (in_slope == '0) || (dneg != sneg);
        q_data.order   = order_clamped;
    end

endmodule

// ----- hdl/slinv_mul.sv -----
// ----------------------------------------------------------------------------
// slinv_mul - shared fixed point multiplier
// 64 by 64 product from four 32 by 32 partial products, scaled down by
// the fraction bits and saturated at 2^63-1.
// ----------------------------------------------------------------------------
module slinv_mul
    import slinv_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sel_reg, sel_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [63:0]  res_reg, res_next;
    logic [31:0]  pa, pb;
    logic [127:0] shr;

    assign pa  = sel_next[1] ? a_reg[63:32] : a_reg[31:0];
    assign pb  = sel_next[0] ? b_reg[63:32] : b_reg[31:0];
    assign shr = acc_reg >> RATIO_FRAC_BITS;

    // partial product and accumulate sequence
    always_comb
    begin
        acc_next  = acc_reg;
        pp_next   = pp_reg;
        sel_next  = cnt_reg[1:0];
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (req.start)
        begin
            acc_next  = '0;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd0 && cnt_reg != 3'd5)
            begin
                acc_next = acc_reg + (128'(pp_reg) << (7'd32 * ({6'd0, sel_reg[1]}
                           + {6'd0, sel_reg[0]})));
            end
            if (cnt_reg < 3'd4)
            begin
                pp_next = 64'(pa) * 64'(pb);
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd5)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = (|shr[127:63]) ? CAP63 : shr[63:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sel_reg <= sel_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ----- hdl/slinv_div.sv -----
// ----------------------------------------------------------------------------
// slinv_div - shared fixed point divider
// Restoring division, one quotient bit per cycle, floor(a*2^F/b)
// saturated at 2^63-1, zero divisor gives the saturation value.
// ----------------------------------------------------------------------------
module slinv_div
    import slinv_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    localparam int ITER = 64 + RATIO_FRAC_BITS;
    localparam int CW   = $clog2(ITER + 1);

    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg;
    logic [63:0]   rem_reg, rem_next;
    logic [63:0]   q_reg, q_next;
    logic          sat_reg, sat_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [63:0]   res_reg, res_next;
    logic [63:0]   rs;
    logic          ge;

    // one restoring step
    assign rs = {rem_reg[62:0], a_reg[63]};
    assign ge = rem_reg[63] || (rs >= b_reg);

    always_comb
    begin
        a_next    = a_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (req.start)
        begin
            a_next    = req.a;
            rem_next  = '0;
            q_next    = '0;
            sat_next  = 1'b0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = CAP63;
            end
            else
            begin
                a_next   = {a_reg[62:0], 1'b0};
                rem_next = ge ? (rs - b_reg) : rs;
                sat_next = sat_reg | q_reg[62];
                q_next   = {q_reg[62:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ITER - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = (sat_reg | q_reg[62]) ? CAP63 : {q_reg[62:0], ge};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            b_reg <= req.b;
        end
        a_reg   <= a_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ----- hdl/slinv_back.sv -----
// ----------------------------------------------------------------------------
// slinv_back - search sequencer of the slope limiter inverse
// Takes classified items from the queue, forms the ratio, runs the
// closed form, the bound expansion, the crossing search and the
// bisection on the shared multiplier and divider, and holds the result.
// ----------------------------------------------------------------------------
module slinv_back
    import slinv_pkg::*;
#(
    parameter int DATA_WIDTH        = DATA_WIDTH_DEF,
    parameter int RATIO_FRAC_BITS   = RATIO_FRAC_BITS_DEF,
    parameter int BISECT_STEPS      = BISECT_STEPS_DEF,
    parameter int SEARCH_LIMIT_LOG2 = SEARCH_LIMIT_LOG2_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  q_entry_t              q_data,
    output logic                  q_pop,
    output arith_req_t            mul_req,
    input  arith_rsp_t            mul_rsp,
    output arith_req_t            div_req,
    input  arith_rsp_t            div_rsp,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_value,
    output logic [2:0]            out_status
);

    localparam int          CW    = $clog2(BISECT_STEPS + 1);
    localparam logic [63:0] ONE   = 64'd1 << RATIO_FRAC_BITS;
    localparam logic [63:0] LIMIT = 64'd1 << (RATIO_FRAC_BITS + SEARCH_LIMIT_LOG2);
    localparam logic [63:0] SBIT  = 64'd1 << (DATA_WIDTH - 1);

    back_state_t   state_reg, state_next;
    back_state_t   ret_reg, ret_next;
    q_entry_t      item_reg, item_next;
    logic [63:0]   ratio_reg, ratio_next;
    logic [63:0]   l_reg, l_next;
    logic [63:0]   r_reg, r_next;
    logic [63:0]   m_reg, m_next;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   evx_reg, evx_next;
    logic [63:0]   f_reg, f_next;
    logic [63:0]   pw_reg, pw_next;
    logic [63:0]   u_reg, u_next;
    logic [63:0]   p_reg, p_next;
    logic [63:0]   t_reg, t_next;
    logic          big_reg, big_next;
    logic [3:0]    k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    st_reg, st_next;
    logic [63:0]   res_reg, res_next;
    logic          out_vld_reg, out_vld_next;
    logic [DATA_WIDTH-1:0] out_val_reg, out_val_next;
    logic [2:0]    out_st_reg, out_st_next;

    logic [63:0]   rcap, gap, mid, cpt, dbl, cap, mag;

    // shared helper values
    assign rcap = (div_rsp.res > RATIO_CAP) ? RATIO_CAP : div_rsp.res;
    assign gap  = (ratio_reg > (ONE << 1)) ? (ratio_reg - (ONE << 1))
                                           : ((ONE << 1) - ratio_reg);
    assign mid  = (l_reg + r_reg) >> 1;
    assign cpt  = (m_reg + ONE) >> 1;
    assign dbl  = (r_reg << 1);
    assign cap  = item_reg.dneg ? SBIT : (SBIT - 64'd1);
    assign mag  = (mul_rsp.res > cap) ? cap : mul_rsp.res;

    // sequencer next state and unit requests
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        item_next    = item_reg;
        ratio_next   = ratio_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        m_next       = m_reg;
        x_next       = x_reg;
        evx_next     = evx_reg;
        f_next       = f_reg;
        pw_next      = pw_reg;
        u_next       = u_reg;
        p_next       = p_reg;
        t_next       = t_reg;
        big_next     = big_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        out_vld_next = out_vld_reg && !out_ready;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;
        q_pop        = 1'b0;
        mul_req      = '{start: 1'b0, a: p_reg, b: p_reg};
        div_req      = '{start: 1'b0, a: item_reg.sm, b: item_reg.dm};
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_data;
                    if (q_data.trivial)
                    begin
                        res_next   = '0;
                        st_next    = ST_SIGN;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_req    = '{start: 1'b1, a: q_data.sm, b: q_data.dm};
                        state_next = S_RATIO;
                    end
                end
            end
            S_RATIO:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = rcap;
                    st_next    = (rcap >= (ONE << 1)) ? ST_TWO : ST_OK;
                    cnt_next   = '0;
                    if (rcap == '0)
                    begin
                        res_next   = '0;
                        st_next    = ST_UNDER;
                        state_next = S_EMIT;
                    end
                    else if (rcap == ONE)
                    begin
                        res_next   = item_reg.diff;
                        st_next    = ST_ONE;
                        state_next = S_EMIT;
                    end
                    else if (item_reg.order == 4'd1)
                    begin
                        state_next = S_ORD1;
                    end
                    else if (item_reg.order == 4'd2)
                    begin
                        if (rcap < ONE)
                        begin
                            l_next     = '0;
                            r_next     = ONE;
                            state_next = S_BIS;
                        end
                        else
                        begin
                            l_next     = ONE;
                            r_next     = ONE << 2;
                            state_next = S_EXP;
                        end
                    end
                    else
                    begin
                        l_next     = ONE >> 2;
                        r_next     = ONE >> 1;
                        state_next = S_CROSS;
                    end
                end
            end
            // order one closed form, first cycle starts the divide unless the gap is zero
            S_ORD1:
            begin
                if (!big_reg)
                begin
                    if (gap == '0)
                    begin
                        x_next     = CAP63;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_req  = '{start: 1'b1, a: ratio_reg, b: gap};
                        big_next = 1'b1;
                    end
                end
                else if (div_rsp.done)
                begin
                    big_next   = 1'b0;
                    x_next     = div_rsp.res;
                    state_next = S_FIN;
                end
            end
            // upper bound expansion for order two
            S_EXP:
            begin
                evx_next   = r_reg;
                ret_next   = S_EXP_CHK;
                state_next = S_EV_START;
            end
            S_EXP_CHK:
            begin
                if (f_reg < ratio_reg && r_reg < LIMIT)
                begin
                    r_next     = (dbl > LIMIT) ? LIMIT : dbl;
                    state_next = S_EXP;
                end
                else
                begin
                    if (f_reg == ratio_reg)
                        l_next = r_reg;
                    cnt_next   = '0;
                    state_next = S_BIS;
                end
            end
            // crossing point search
            S_CROSS:
            begin
                if (cnt_reg == CW'(BISECT_STEPS))
                begin
                    state_next = S_CROSS_END;
                end
                else
                begin
                    m_next     = mid;
                    evx_next   = mid;
                    ret_next   = S_CROSS_CHK;
                    state_next = S_EV_START;
                end
            end
            S_CROSS_CHK:
            begin
                if (f_reg == cpt)
                begin
                    state_next = S_CROSS_END;
                end
                else
                begin
                    if (f_reg < cpt)
                        l_next = m_reg;
                    else
                        r_next = m_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_CROSS;
                end
            end
            S_CROSS_END:
            begin
                if (ratio_reg < f_reg)
                begin
                    st_next    = ST_BELOW;
                    l_next     = '0;
                    r_next     = m_reg;
                    cnt_next   = '0;
                    state_next = S_BIS;
                end
                else
                begin
                    x_next     = (ratio_reg << 1) - ONE;
                    state_next = S_FIN;
                end
            end
            // fixed length bisection toward the ratio
            S_BIS:
            begin
                if (cnt_reg == CW'(BISECT_STEPS))
                begin
                    x_next     = m_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    m_next     = mid;
                    evx_next   = mid;
                    ret_next   = S_BIS_CHK;
                    state_next = S_EV_START;
                end
            end
            S_BIS_CHK:
            begin
                if (f_reg < ratio_reg)
                    l_next = m_reg;
                else
                    r_next = m_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_BIS;
            end
            // scale back by the difference
            S_FIN:
            begin
                mul_req    = '{start: 1'b1, a: item_reg.dm, b: x_reg};
                state_next = S_FIN_W;
            end
            S_FIN_W:
            begin
                if (mul_rsp.done)
                begin
                    res_next   = item_reg.dneg ? (64'd0 - mag) : mag;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_next = 1'b1;
                    out_val_next = res_reg[DATA_WIDTH-1:0];
                    out_st_next  = st_reg;
                    state_next   = S_IDLE;
                end
            end
            // limiter evaluation at evx
            S_EV_START:
            begin
                pw_next = ONE;
                if (evx_reg <= ONE)
                begin
                    big_next   = 1'b0;
                    k_next     = item_reg.order;
                    state_next = S_EV_POW;
                end
                else
                begin
                    big_next   = 1'b1;
                    div_req    = '{start: 1'b1, a: ONE, b: evx_reg};
                    state_next = S_EV_INV;
                end
            end
            S_EV_INV:
            begin
                if (div_rsp.done)
                begin
                    u_next     = div_rsp.res;
                    k_next     = item_reg.order - 4'd1;
                    state_next = S_EV_POW;
                end
            end
            S_EV_POW:
            begin
                if (k_reg == 4'd0)
                begin
                    if (big_reg)
                    begin
                        mul_req    = '{start: 1'b1, a: pw_reg, b: u_reg};
                        state_next = S_EV_P;
                    end
                    else
                    begin
                        p_next     = pw_reg;
                        mul_req    = '{start: 1'b1, a: pw_reg, b: pw_reg};
                        state_next = S_EV_T;
                    end
                end
                else
                begin
                    mul_req    = '{start: 1'b1, a: pw_reg, b: big_reg ? u_reg : evx_reg};
                    k_next     = k_reg - 4'd1;
                    state_next = S_EV_POW_W;
                end
            end
            S_EV_POW_W:
            begin
                if (mul_rsp.done)
                begin
                    pw_next    = mul_rsp.res;
                    state_next = S_EV_POW;
                end
            end
            S_EV_P:
            begin
                if (mul_rsp.done)
                begin
                    p_next     = mul_rsp.res;
                    mul_req    = '{start: 1'b1, a: mul_rsp.res, b: pw_reg};
                    state_next = S_EV_T;
                end
            end
            S_EV_T:
            begin
                if (mul_rsp.done)
                begin
                    t_next     = mul_rsp.res;
                    mul_req    = '{start: 1'b1, a: p_reg + ONE, b: p_reg + ONE};
                    state_next = S_EV_DEN;
                end
            end
            S_EV_DEN:
            begin
                if (mul_rsp.done)
                begin
                    div_req    = '{start: 1'b1,
                                   a: big_reg ? ((ONE + t_reg) << 1) : ((t_reg + evx_reg) << 1),
                                   b: mul_rsp.res};
                    state_next = S_EV_DIV;
                end
            end
            S_EV_DIV:
            begin
                if (div_rsp.done)
                begin
                    f_next     = div_rsp.res;
                    big_next   = 1'b0;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            big_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            big_reg     <= big_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        ratio_reg   <= ratio_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        m_reg       <= m_next;
        x_reg       <= x_next;
        evx_reg     <= evx_next;
        f_reg       <= f_next;
        pw_reg      <= pw_next;
        u_reg       <= u_next;
        p_reg       <= p_next;
        t_reg       <= t_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        st_reg      <= st_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    assign out_valid  = out_vld_reg;
    assign out_value  = out_val_reg;
    assign out_status = out_st_reg;

    // sign mismatch and underflow results are zero
    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_st_reg == ST_SIGN || out_st_reg == ST_UNDER)
        |-> out_val_reg == '0)
        else $error("nonzero value with sign or underflow status");

    // status code stays within the defined set
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_st_reg <= ST_BELOW)
        else $error("undefined status code");

    // a new result only comes from the emit state
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    // queue is only popped when the sequencer is free
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_RATIO || state_reg == S_EMIT)
        else $error("pop without start of item");

endmodule

// ----- hdl/slope_limiter_inverse.sv -----
// ----------------------------------------------------------------------------
// slope_limiter_inverse - inverse of a family of slope limiters
// Finds the limiter argument that gives slope/difference and returns it
// scaled by the difference, with a status code.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one item per transfer: difference and target_slope.
//   m_axis returns one result per item, in order: reconstructed_value and
//   status. cfg_* writes limiter_order (reset value 1); write it only
//   while no item is in flight.
//   Work per item: the ratio takes one divide. One limiter evaluation of
//   order n runs its multiplies plus one or two divides. Order 1 costs at
//   most two divides. Order 2 runs up to SEARCH_LIMIT_LOG2-1 bound checks
//   plus BISECT_STEPS evaluations, orders 3 and up run the crossing search
//   and the bisection, up to 2*BISECT_STEPS evaluations. Trivial, underflow
//   and ratio one items run no search. All of it runs on the shared divider
//   and multiplier.
//   Throughput: one item at a time in the back end; a two entry queue
//   lets the input side keep taking items meanwhile.
//   Reset clears the queue, the output register and sets the order to 1.
//   A stalled m_axis holds its result; the back end waits, the queue fills
//   and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module slope_limiter_inverse
    import slinv_pkg::*;
#(
    parameter int DATA_WIDTH        = DATA_WIDTH_DEF,
    parameter int RATIO_FRAC_BITS   = RATIO_FRAC_BITS_DEF,
    parameter int BISECT_STEPS      = BISECT_STEPS_DEF,
    parameter int MAX_ORDER         = MAX_ORDER_DEF,
    parameter int SEARCH_LIMIT_LOG2 = SEARCH_LIMIT_LOG2_DEF,
    localparam int IN_TW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((DATA_WIDTH + 3 + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data,       // limiter_order
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // difference, target_slope, zero fill
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata    // reconstructed_value, status, zero fill
);

    logic                  q_full, q_push, q_pop, q_valid;
    q_entry_t              q_in, q_out;
    arith_req_t            mul_req, div_req;
    arith_rsp_t            mul_rsp, div_rsp;
    logic [DATA_WIDTH-1:0] out_value;
    logic [2:0]            out_status;

    // input side
    slinv_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_ORDER  (MAX_ORDER)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_diff   (s_axis_tdata[DATA_WIDTH-1:0]),
        .in_slope  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // queue between the two sides
    slinv_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    // shared arithmetic units
    slinv_mul #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    slinv_div #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // search sequencer and output register
    slinv_back #(
        .DATA_WIDTH        (DATA_WIDTH),
        .RATIO_FRAC_BITS   (RATIO_FRAC_BITS),
        .BISECT_STEPS      (BISECT_STEPS),
        .SEARCH_LIMIT_LOG2 (SEARCH_LIMIT_LOG2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (out_value),
        .out_status (out_status)
    );

    assign m_axis_tdata = OUT_TW'({out_status, out_value});

endmodule

// ----- sim/tb_slope_limiter_inverse.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slope_limiter_inverse - self-checking bench of the slope limiter inverse
// Streams difference/slope pairs through the block under every limiter
// order, predicts each reconstructed value and status with a bit-true
// fixed point model and checks the results in order, with random bursts,
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_slope_limiter_inverse;
    import slinv_pkg::*;

    localparam int          FRAC      = RATIO_FRAC_BITS_DEF;
    localparam int          STEPS     = BISECT_STEPS_DEF;
    localparam int          ORDER_TOP = MAX_ORDER_DEF;
    localparam logic [63:0] ONE       = 64'd1 << FRAC;
    localparam logic [63:0] HI_LIMIT  = ONE << SEARCH_LIMIT_LOG2_DEF;
    localparam int          IDLE_LIMIT = 300000;
    localparam int          PHASE_ITEMS = 165;

    typedef logic [63:0] word_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } slinv_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;      // difference, target_slope
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;      // reconstructed_value, status, zero fill

    slinv_result_t expected_results[$];
    logic [3:0]    order_reg;
    word_t         cross_x[0:15];
    word_t         cross_y[0:15];
    int            errors;
    int            burst_left;
    int            hold_len;
    int            idle_cycles;
    int            stall_pct;
    int            stall_cnt;

    slope_limiter_inverse uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // fixed point product, truncated and saturated
    function automatic word_t fx_mul(word_t a, word_t b);
        logic [127:0] p;
        p = a * b;
        if (p[127:64+FRAC] != 0)
            return CAP63;
        p = p >> FRAC;
        if (p[63:0] > CAP63)
            return CAP63;
        return p[63:0];
    endfunction

    // fixed point quotient, truncated and saturated
    function automatic word_t fx_div(word_t a, word_t b);
        logic [127:0] q;
        if (b == 0)
            return CAP63;
        q = ({64'd0, a} << FRAC) / {64'd0, b};
        if (q >= 128'h8000_0000_0000_0000)
            return CAP63;
        return q[63:0];
    endfunction

    function automatic word_t fx_pow(word_t x, int k);
        word_t r;
        r = ONE;
        for (int i = 0; i < k; i++)
            r = fx_mul(r, x);
        return r;
    endfunction

    // limiter value of order n at x
    function automatic word_t limiter_value(int n, word_t x);
        word_t p, q, u, num, den;
        if (x <= ONE)
        begin
            p   = fx_pow(x, n);
            num = 2 * (fx_mul(p, p) + x);
            den = fx_mul(p + ONE, p + ONE);
        end
        else
        begin
            u   = fx_div(ONE, x);
            q   = fx_pow(u, n - 1);
            p   = fx_mul(q, u);
            num = 2 * (ONE + fx_mul(p, q));
            den = fx_mul(ONE + p, ONE + p);
        end
        return fx_div(num, den);
    endfunction

    function automatic word_t root_search(int n, word_t lo, word_t hi, word_t goal);
        word_t m;
        m = lo;
        for (int i = 0; i < STEPS; i++)
        begin
            m = (lo + hi) >> 1;
            if (limiter_value(n, m) < goal)
                lo = m;
            else
                hi = m;
        end
        return m;
    endfunction

    // crossing point of the smooth and linear branches
    task automatic build_crossings();
        word_t lo, hi, m, y, c;
        for (int n = 3; n <= ORDER_TOP; n++)
        begin
            lo = ONE >> 2;
            hi = ONE >> 1;
            m  = lo;
            y  = limiter_value(n, m);
            for (int i = 0; i < STEPS; i++)
            begin
                m = (lo + hi) >> 1;
                y = limiter_value(n, m);
                c = (m + ONE) >> 1;
                if (y < c)
                    lo = m;
                else if (y == c)
                    break;
                else
                    hi = m;
            end
            cross_x[n] = m;
            cross_y[n] = y;
        end
    endtask

    // expected result of one item under the given order
    function automatic slinv_result_t inverse_result(logic [3:0] ord, logic [31:0] d,
                                                     logic [31:0] s);
        slinv_result_t res;
        word_t dm, sm, ratio, x, gap, lo, hi, y, mag, cap;
        int n;
        res.status = ST_OK;
        res.value  = '0;
        if (d == 0 || s == 0 || d[31] != s[31])
        begin
            res.status = ST_SIGN;
            return res;
        end
        dm    = d[31] ? {32'd0, -d} : {32'd0, d};
        sm    = s[31] ? {32'd0, -s} : {32'd0, s};
        ratio = fx_div(sm, dm);
        if (ratio > RATIO_CAP)
            ratio = RATIO_CAP;
        if (ratio == 0)
        begin
            res.status = ST_UNDER;
            return res;
        end
        if (ratio == ONE)
        begin
            res.status = ST_ONE;
            res.value  = d;
            return res;
        end
        if (ratio >= 2 * ONE)
            res.status = ST_TWO;
        n = ord;
        if (n < 1)
            n = 1;
        if (n > ORDER_TOP)
            n = ORDER_TOP;
        if (n == 1)
        begin
            gap = (ratio > 2 * ONE) ? ratio - 2 * ONE : 2 * ONE - ratio;
            x   = (gap == 0) ? CAP63 : fx_div(ratio, gap);
        end
        else if (n == 2)
        begin
            if (ratio < ONE)
                x = root_search(2, 0, ONE, ratio);
            else
            begin
                lo = ONE;
                hi = 4 * ONE;
                forever
                begin
                    y = limiter_value(2, hi);
                    if (y < ratio && hi < HI_LIMIT)
                    begin
                        hi = hi << 1;
                        if (hi > HI_LIMIT)
                            hi = HI_LIMIT;
                        continue;
                    end
                    if (y == ratio)
                        lo = hi;
                    break;
                end
                x = root_search(2, lo, hi, ratio);
            end
        end
        else if (ratio < cross_y[n])
        begin
            res.status = ST_BELOW;
            x = root_search(n, 0, cross_x[n], ratio);
        end
        else
            x = 2 * ratio - ONE;
        mag = fx_mul(dm, x);
        cap = d[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > cap)
            mag = cap;
        res.value = d[31] ? -mag[31:0] : mag[31:0];
        return res;
    endfunction

    // predict on every input transfer
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(inverse_result(order_reg, s_axis_tdata[31:0],
                                                      s_axis_tdata[63:32]));
    end

    // check every output transfer
    always @(posedge clk)
    begin
        slinv_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value %h status %0d", $time,
                         m_axis_tdata[31:0], m_axis_tdata[34:32]);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.value)
                begin
                    $display("%0t: reconstructed_value expected %h actual %h", $time,
                             exp_r.value, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[34:32] !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, m_axis_tdata[34:32]);
                    errors++;
                end
            end
        end
    end

    // output side stalls, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_len > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_len = hold_len - 1;
        end
        else
        begin
            stall_cnt = stall_cnt + 1;
            if (stall_cnt % 700 == 0)
                stall_pct = $urandom_range(0, 3) * 25;
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on transfer activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one item; entered and left just after a rising edge
    task automatic send_item(logic [31:0] d, logic [31:0] s);
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left    = burst_left - 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s, d};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_order(logic [3:0] ord);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= ord;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        order_reg = ord;
    endtask

    // random item, mostly same-sign pairs with a useful ratio
    task automatic send_random();
        logic [31:0] d, s;
        logic [63:0] dmag, smag;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            d = $urandom();
            s = $urandom();
        end
        else if (kind < 28)
        begin
            d = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom();
            s = ($urandom_range(0, 1) != 0) ? 32'd0
                                            : {~d[31], 31'($urandom_range(1, 1000))};
        end
        else
        begin
            dmag = {32'd0, $urandom()} & ((64'd1 << $urandom_range(1, 31)) - 1);
            dmag = dmag | 64'd1;
            smag = (dmag * $urandom_range(1, 3 << 16)) >> 16;
            if ($urandom_range(0, 9) == 0)
                smag = dmag + $urandom_range(0, 2) * dmag / 2;
            if (smag == 0)
                smag = 1;
            if (smag > 64'h7FFF_FFFF)
                smag = 64'h7FFF_FFFF;
            if ($urandom_range(0, 1) != 0)
            begin
                d = -dmag[31:0];
                s = -smag[31:0];
            end
            else
            begin
                d = dmag[31:0];
                s = smag[31:0];
            end
        end
        send_item(d, s);
    endtask

    // special cases and field extremes
    task automatic test_directed();
        send_item(32'h0001_0000, 32'hFFFF_0000);   // signs differ
        send_item(32'h0000_0000, 32'h0001_0000);   // zero difference
        send_item(32'h0001_0000, 32'h0000_0000);   // zero slope
        send_item(32'h7FFF_FFFF, 32'h0000_0001);   // ratio underflow
        send_item(32'h0003_0000, 32'h0003_0000);   // ratio one
        send_item(32'h8000_0000, 32'h8000_0000);   // ratio one, most negative
        send_item(32'h0001_0000, 32'h0002_0000);   // ratio two, order one saturates
        send_item(32'h8000_0000, 32'hFFFF_FFFF);   // tiny ratio with negative inputs, underflows
        send_item(32'h0000_0001, 32'h7FFF_FFFF);   // huge ratio
        send_item(32'hFFFF_FFFF, 32'h8000_0000);   // huge negative ratio
        send_item(32'h0004_0000, 32'h0003_0000);   // ratio below one
        write_order(4'd2);
        send_item(32'h0004_0000, 32'h0001_0000);   // below one
        send_item(32'h0002_0000, 32'h0003_0000);   // above one
        send_item(32'h0000_0001, 32'h7FFF_FFFF);   // upper bound saturates
        send_item(32'hFFFE_0000, 32'hFFFC_0000);   // ratio two
        write_order(4'd5);
        send_item(32'h0010_0000, 32'h0001_0000);   // below crossing
        send_item(32'h0001_0000, 32'h0001_8000);   // linear region
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFE);   // just below one
        write_order(4'd0);
        send_item(32'h0001_0000, 32'h0001_8000);
        write_order(4'd15);
        send_item(32'h0010_0000, 32'h0001_0000);
        send_item(32'hFFF0_0000, 32'hFFFF_0000);
    endtask

    // output held off while input keeps offering items
    task automatic test_backpressure();
        write_order(4'd3);
        hold_len = 40000;
        for (int i = 0; i < 12; i++)
            send_random();
    endtask

    task automatic test_random_orders();
        logic [3:0] orders[11] = '{4'd1, 4'd9, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                                   4'd8, 4'd0, 4'd15};
        for (int p = 0; p < 11; p++)
        begin
            write_order(orders[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
        end
        write_order(4'd1);
        for (int i = 0; i < 30; i++)
            send_random();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 4'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        order_reg     = 4'd1;
        errors        = 0;
        burst_left    = 0;
        hold_len      = 0;
        idle_cycles   = 0;
        stall_pct     = 0;
        stall_cnt     = 0;
        build_crossings();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_orders();

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
